// ===== rtl/dltq_pkg.sv =====
// Package for the delta-list timer queue: sizes, request codes, status codes.
// No dependencies.
`timescale 1ns / 1ps
package dltq_pkg;
   localparam int DEPTH      = 16;
   localparam int ID_BITS    = 8;
   localparam int DELAY_BITS = 16;
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);
   localparam int SW = DELAY_BITS + CW;
   localparam int WW = ID_BITS + DELAY_BITS;
   localparam int STAT_BITS = 4;

   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_TICK   = 2'd2;
   localparam logic [1:0] REQ_POP    = 2'd3;

   localparam logic [STAT_BITS-1:0] ST_INSERTED = 4'd0;
   localparam logic [STAT_BITS-1:0] ST_ZERO     = 4'd1;
   localparam logic [STAT_BITS-1:0] ST_FULL     = 4'd2;
   localparam logic [STAT_BITS-1:0] ST_REMOVED  = 4'd3;
   localparam logic [STAT_BITS-1:0] ST_NOTFOUND = 4'd4;
   localparam logic [STAT_BITS-1:0] ST_EXPIRED  = 4'd5;
   localparam logic [STAT_BITS-1:0] ST_NONE     = 4'd6;
   localparam logic [STAT_BITS-1:0] ST_POPPED   = 4'd7;
   localparam logic [STAT_BITS-1:0] ST_EMPTY    = 4'd8;

   typedef logic [WW-1:0] word_type;
endpackage

// ===== rtl/dltq_if.sv =====
// Request and response channel interfaces, valid/ready handshake.
// Depends on dltq_pkg.
`timescale 1ns / 1ps
interface dltq_req_if;
   logic                            valid;
   logic                            ready;
   logic [1:0]                      req_type;
   logic [dltq_pkg::ID_BITS-1:0]    task_id;
   logic [dltq_pkg::DELAY_BITS-1:0] delay;
   modport source (output valid, req_type, task_id, delay, input ready);
   modport sink   (input valid, req_type, task_id, delay, output ready);
endinterface

interface dltq_rsp_if;
   logic                           valid;
   logic                           ready;
   logic [dltq_pkg::STAT_BITS-1:0] status;
   logic [dltq_pkg::ID_BITS-1:0]   out_task_id;
   logic                           last;
   modport source (output valid, status, out_task_id, last, input ready);
   modport sink   (input valid, status, out_task_id, last, output ready);
endinterface

// ===== rtl/dltq_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`timescale 1ns / 1ps
module dltq_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;
endmodule

// ===== rtl/delta_list_timer_queue_unit.sv =====
// Delta-list timer queue: sequencer around one entry RAM of {task, delta}.
// Depends on dltq_pkg, dltq_if, dltq_ram.
//
// channel   dir  payload                         transfer
// req_chan  in   req_type, task_id, delay        valid & ready
// rsp_chan  out  status, out_task_id, last       valid & ready
//
// Entry k sits at RAM address k; the single RAM read port sets the pace.
// Insert: scan, shift up, write the new entry, respond.
// Remove/pop: scan to the match, then shift down and respond.
// Tick: check the head and respond; each expired task adds a shift down and
// a step to the next head before its response.
// Reset is synchronous and empties the queue; a stalled response holds the sequencer.
`timescale 1ns / 1ps
module delta_list_timer_queue_unit (
   input logic         clock,
   input logic         reset,
   dltq_req_if.sink    req_chan,
   dltq_rsp_if.source  rsp_chan
);
   import dltq_pkg::*;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_SHUP  = 4'd2;
   localparam logic [3:0] S_WRNEW = 4'd3;
   localparam logic [3:0] S_SHDN  = 4'd4;
   localparam logic [3:0] S_TCHK  = 4'd5;
   localparam logic [3:0] S_TNEXT = 4'd6;
   localparam logic [3:0] S_EMIT  = 4'd7;

   localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
   localparam logic [CW-1:0] CNT_ONE  = CW'(1);

   logic [3:0]            state_ff, state_in, ret_ff, ret_in;
   logic [1:0]            op_ff, op_in;
   logic [ID_BITS-1:0]    id_ff, id_in, pend_id_ff, pend_id_in;
   logic [DELAY_BITS-1:0] delay_ff, delay_in, newd_ff, newd_in;
   logic [DELAY_BITS-1:0] split_ff, split_in, d_ff, d_in;
   logic [CW-1:0]         cnt_ff, cnt_in, idx_ff, idx_in, pos_ff, pos_in;
   logic [CW-1:0]         rd_ff, rd_in, wr_ff, wr_in, left_ff, left_in;
   logic [SW-1:0]         sum_ff, sum_in;
   logic                  pend_ff, pend_in, sfirst_ff, sfirst_in, tfirst_ff, tfirst_in;
   logic [STAT_BITS-1:0]  em_status_ff, em_status_in, rsp_status_ff, rsp_status_in;
   logic [ID_BITS-1:0]    em_id_ff, em_id_in, rsp_id_ff, rsp_id_in;
   logic                  em_last_ff, em_last_in, rsp_last_ff, rsp_last_in;
   logic                  rsp_valid_ff, rsp_valid_in;

   logic                  wr_en;
   logic [AW-1:0]         wr_addr, rd_addr;
   word_type              wr_data, rd_data;
   logic [DELAY_BITS-1:0] rd_delta, dec;
   logic [ID_BITS-1:0]    rd_task;
   logic [SW-1:0]         scan_sum;
   logic                  scan_last, hit;

   dltq_ram #(.WIDTH(WW), .DEPTH(DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_delta  = rd_data[DELAY_BITS-1:0];
   assign rd_task   = rd_data[WW-1:DELAY_BITS];
   assign dec       = rd_delta - DELAY_BITS'(rd_delta != '0);
   assign scan_sum  = sum_ff + SW'(rd_delta);
   assign scan_last = (idx_ff == cnt_ff - CNT_ONE);
   assign hit       = (op_ff == REQ_POP) || (rd_task == id_ff);

   assign req_chan.ready       = (state_ff == S_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.out_task_id = rsp_id_ff;
   assign rsp_chan.last        = rsp_last_ff;

   always_comb begin
      state_in = state_ff;  ret_in = ret_ff;  op_in = op_ff;
      id_in = id_ff;  pend_id_in = pend_id_ff;  delay_in = delay_ff;
      newd_in = newd_ff;  split_in = split_ff;  d_in = d_ff;
      cnt_in = cnt_ff;  idx_in = idx_ff;  pos_in = pos_ff;
      rd_in = rd_ff;  wr_in = wr_ff;  left_in = left_ff;  sum_in = sum_ff;
      pend_in = pend_ff;  sfirst_in = sfirst_ff;  tfirst_in = tfirst_ff;
      em_status_in = em_status_ff;  em_id_in = em_id_ff;  em_last_in = em_last_ff;
      rsp_status_in = rsp_status_ff;  rsp_id_in = rsp_id_ff;  rsp_last_in = rsp_last_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_chan.ready;
      wr_en = 1'b0;  wr_addr = '0;  wr_data = '0;  rd_addr = '0;

      case (state_ff)
         S_IDLE: begin
            if (req_chan.valid) begin
               op_in = req_chan.req_type;
               id_in = req_chan.task_id;
               delay_in = req_chan.delay;
               idx_in = '0;
               sum_in = '0;
               em_id_in = '0;
               em_last_in = 1'b1;
               ret_in = S_IDLE;
               state_in = S_SCAN;
               case (req_chan.req_type)
                  REQ_INSERT: begin
                     if (req_chan.delay == '0) begin
                        em_status_in = ST_ZERO;
                        state_in = S_EMIT;
                     end else if (cnt_ff == CNT_FULL) begin
                        em_status_in = ST_FULL;
                        state_in = S_EMIT;
                     end else if (cnt_ff == '0) begin
                        pos_in = '0;
                        newd_in = req_chan.delay;
                        state_in = S_WRNEW;
                     end
                  end
                  REQ_REMOVE: begin
                     if (cnt_ff == '0) begin
                        em_status_in = ST_NOTFOUND;
                        state_in = S_EMIT;
                     end
                  end
                  REQ_POP: begin
                     if (cnt_ff == '0) begin
                        em_status_in = ST_EMPTY;
                        state_in = S_EMIT;
                     end
                  end
                  default: begin
                     if (cnt_ff == '0) begin
                        em_status_in = ST_NONE;
                        state_in = S_EMIT;
                     end else begin
                        tfirst_in = 1'b1;
                        state_in = S_TCHK;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            rd_addr = AW'(idx_ff + CNT_ONE);
            idx_in = idx_ff + CNT_ONE;
            if (op_ff == REQ_INSERT) begin
               sum_in = scan_sum;
               if (SW'(delay_ff) <= scan_sum) begin
                  pos_in = idx_ff;
                  newd_in = delay_ff - sum_ff[DELAY_BITS-1:0];
                  split_in = scan_sum[DELAY_BITS-1:0] - delay_ff;
                  rd_in = cnt_ff - CNT_ONE;
                  left_in = cnt_ff - idx_ff;
                  pend_in = 1'b0;
                  state_in = S_SHUP;
               end else if (scan_last) begin
                  pos_in = cnt_ff;
                  newd_in = delay_ff - scan_sum[DELAY_BITS-1:0];
                  state_in = S_WRNEW;
               end
            end else begin
               if (hit) begin
                  em_status_in = (op_ff == REQ_POP) ? ST_POPPED : ST_REMOVED;
                  em_id_in = rd_task;
                  d_in = rd_delta;
                  rd_in = idx_ff + CNT_ONE;
                  left_in = cnt_ff - CNT_ONE - idx_ff;
                  sfirst_in = 1'b1;
                  pend_in = 1'b0;
                  state_in = S_SHDN;
               end else if (scan_last) begin
                  em_status_in = ST_NOTFOUND;
                  state_in = S_EMIT;
               end
            end
         end
         S_SHUP: begin
            if (pend_ff) begin
               wr_en = 1'b1;
               wr_addr = AW'(wr_ff);
               wr_data = (left_ff == '0) ? {rd_task, split_ff} : rd_data;
            end
            if (left_ff != '0) begin
               rd_addr = AW'(rd_ff);
               pend_in = 1'b1;
               wr_in = rd_ff + CNT_ONE;
               rd_in = rd_ff - CNT_ONE;
               left_in = left_ff - CNT_ONE;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  state_in = S_WRNEW;
               end
            end
         end
         S_WRNEW: begin
            wr_en = 1'b1;
            wr_addr = AW'(pos_ff);
            wr_data = {id_ff, newd_ff};
            cnt_in = cnt_ff + CNT_ONE;
            em_status_in = ST_INSERTED;
            em_id_in = '0;
            em_last_in = 1'b1;
            ret_in = S_IDLE;
            state_in = S_EMIT;
         end
         S_SHDN: begin
            if (pend_ff) begin
               wr_en = 1'b1;
               wr_addr = AW'(wr_ff);
               wr_data = sfirst_ff ? {rd_task, rd_delta + d_ff} : rd_data;
               sfirst_in = 1'b0;
            end
            if (left_ff != '0) begin
               rd_addr = AW'(rd_ff);
               pend_in = 1'b1;
               wr_in = rd_ff - CNT_ONE;
               rd_in = rd_ff + CNT_ONE;
               left_in = left_ff - CNT_ONE;
            end else begin
               pend_in = 1'b0;
               if (!pend_ff) begin
                  cnt_in = cnt_ff - CNT_ONE;
                  state_in = (op_ff == REQ_TICK) ? S_TNEXT : S_EMIT;
               end
            end
         end
         S_TCHK: begin
            d_in = '0;
            rd_in = CNT_ONE;
            left_in = cnt_ff - CNT_ONE;
            sfirst_in = 1'b1;
            pend_in = 1'b0;
            ret_in = S_IDLE;
            if (tfirst_ff) begin
               if (dec != '0) begin
                  wr_en = 1'b1;
                  wr_data = {rd_task, dec};
                  em_status_in = ST_NONE;
                  em_id_in = '0;
                  em_last_in = 1'b1;
                  state_in = S_EMIT;
               end else begin
                  pend_id_in = rd_task;
                  state_in = S_SHDN;
               end
            end else begin
               em_status_in = ST_EXPIRED;
               em_id_in = pend_id_ff;
               state_in = S_EMIT;
               if (rd_delta == '0) begin
                  em_last_in = 1'b0;
                  pend_id_in = rd_task;
                  ret_in = S_SHDN;
               end else begin
                  em_last_in = 1'b1;
               end
            end
         end
         S_TNEXT: begin
            tfirst_in = 1'b0;
            if (cnt_ff == '0) begin
               em_status_in = ST_EXPIRED;
               em_id_in = pend_id_ff;
               em_last_in = 1'b1;
               ret_in = S_IDLE;
               state_in = S_EMIT;
            end else begin
               state_in = S_TCHK;
            end
         end
         S_EMIT: begin
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in = 1'b1;
               rsp_status_in = em_status_ff;
               rsp_id_in = em_id_ff;
               rsp_last_in = em_last_ff;
               state_in = ret_ff;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         cnt_ff <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      ret_ff <= ret_in;  op_ff <= op_in;  id_ff <= id_in;  pend_id_ff <= pend_id_in;
      delay_ff <= delay_in;  newd_ff <= newd_in;  split_ff <= split_in;  d_ff <= d_in;
      idx_ff <= idx_in;  pos_ff <= pos_in;  rd_ff <= rd_in;  wr_ff <= wr_in;
      left_ff <= left_in;  sum_ff <= sum_in;  pend_ff <= pend_in;
      sfirst_ff <= sfirst_in;  tfirst_ff <= tfirst_in;
      em_status_ff <= em_status_in;  em_id_ff <= em_id_in;  em_last_ff <= em_last_in;
      rsp_status_ff <= rsp_status_in;  rsp_id_ff <= rsp_id_in;  rsp_last_ff <= rsp_last_in;
   end

`ifndef SYNTHESIS
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= CNT_FULL) else $error("entry count above depth");
   a_idle_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_IDLE && !req_chan.valid) |=> $stable(cnt_ff))
      else $error("entry count moved while idle");
   a_insert_grows: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_WRNEW) |=> (cnt_ff == $past(cnt_ff) + CNT_ONE))
      else $error("insert did not grow the queue");
`endif
endmodule
